// ===== rtl/tae_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tae_pkg: shared types, codes and decode helpers for the Thumb ALU executor
// Word and index widths, flag and result structs, format and opcode codes,
// and the format/operand decode used by both the top level and the ALU.
// ----------------------------------------------------------------------------
package tae_pkg;

    localparam int INSTR_W     = 16;
    localparam int WORD_W      = 32;
    localparam int REG_COUNT   = 8;
    localparam int REG_IDX_W   = $clog2(REG_COUNT);
    localparam int SHAMT_W     = 8;
    localparam int SHIFT_IDX_W = $clog2(WORD_W);
    localparam int IMM3_W      = 3;
    localparam int IMM5_W      = 5;
    localparam int IMM8_W      = 8;

    typedef logic [INSTR_W-1:0]   instr_t;
    typedef logic [WORD_W-1:0]    word_t;
    typedef logic [REG_IDX_W-1:0] reg_idx_t;
    typedef logic [SHAMT_W-1:0]   shamt_t;

    typedef struct packed {
        logic n;
        logic z;
        logic c;
        logic v;
    } flags_t;

    typedef struct packed {
        word_t    value;
        reg_idx_t dest;
        logic     write;
        flags_t   flags;
        logic     supported;
    } exec_t;

    // Top-bit patterns that identify each executed format
    localparam logic [4:0] FMT_ADDSUB_CODE = 5'b00011;
    localparam logic [2:0] FMT_SHIFT_CODE  = 3'b000;
    localparam logic [2:0] FMT_IMM_CODE    = 3'b001;
    localparam logic [5:0] FMT_ALU_CODE    = 6'b010000;

    typedef enum logic [2:0] {
        FMT_SHIFT,
        FMT_ADDSUB,
        FMT_IMM,
        FMT_ALU,
        FMT_NONE
    } format_t;

    typedef enum logic [3:0] {
        ALU_AND = 4'h0,
        ALU_EOR = 4'h1,
        ALU_LSL = 4'h2,
        ALU_LSR = 4'h3,
        ALU_ASR = 4'h4,
        ALU_ADC = 4'h5,
        ALU_SBC = 4'h6,
        ALU_ROR = 4'h7,
        ALU_TST = 4'h8,
        ALU_NEG = 4'h9,
        ALU_CMP = 4'hA,
        ALU_CMN = 4'hB,
        ALU_ORR = 4'hC,
        ALU_MUL = 4'hD,
        ALU_BIC = 4'hE,
        ALU_MVN = 4'hF
    } alu_op_t;

    typedef enum logic [1:0] {
        IMM_MOV = 2'd0,
        IMM_CMP = 2'd1,
        IMM_ADD = 2'd2,
        IMM_SUB = 2'd3
    } imm_op_t;

    typedef enum logic [1:0] {
        SH_LSL = 2'd0,
        SH_LSR = 2'd1,
        SH_ASR = 2'd2,
        SH_ROR = 2'd3
    } shift_kind_t;

    function automatic format_t decode_format(instr_t ins);
        format_t fmt;
        priority if (ins[15:11] == FMT_ADDSUB_CODE)
            fmt = FMT_ADDSUB;
        else if (ins[15:13] == FMT_SHIFT_CODE)
            fmt = FMT_SHIFT;
        else if (ins[15:13] == FMT_IMM_CODE)
            fmt = FMT_IMM;
        else if (ins[15:10] == FMT_ALU_CODE)
            fmt = FMT_ALU;
        else
            fmt = FMT_NONE;
        return fmt;
    endfunction

    // First operand: Rs for shift and add/sub, Rd for immediate and ALU forms
    function automatic reg_idx_t src_a_index(instr_t ins);
        reg_idx_t idx;
        unique case (decode_format(ins))
            FMT_IMM:  idx = ins[10:8];
            FMT_ALU:  idx = ins[2:0];
            default:  idx = ins[5:3];
        endcase
        return idx;
    endfunction

    // Second operand: Rn for add/sub, Rs for ALU forms
    function automatic reg_idx_t src_b_index(instr_t ins);
        reg_idx_t idx;
        if (decode_format(ins) == FMT_ADDSUB)
            idx = ins[8:6];
        else
            idx = ins[5:3];
        return idx;
    endfunction

endpackage

// ===== rtl/tae_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tae_if: valid/ready channels of the Thumb ALU executor
// Issue channel carries one instruction word; result channel carries the
// executed value, destination, write flag, flags and supported bit.
// ----------------------------------------------------------------------------
interface tae_issue_if;
    logic                   valid;
    logic                   ready;
    logic [tae_pkg::INSTR_W-1:0] instruction;

    modport source (output valid, output instruction, input ready);
    modport sink   (input valid, input instruction, output ready);
endinterface

interface tae_result_if;
    logic                          valid;
    logic                          ready;
    logic [tae_pkg::WORD_W-1:0]    result_value;
    logic [tae_pkg::REG_IDX_W-1:0] dest_index;
    logic                          reg_written;
    logic                          flag_n;
    logic                          flag_z;
    logic                          flag_c;
    logic                          flag_v;
    logic                          supported;

    modport source (
        output valid, output result_value, output dest_index, output reg_written,
        output flag_n, output flag_z, output flag_c, output flag_v,
        output supported, input ready
    );
    modport sink (
        input valid, input result_value, input dest_index, input reg_written,
        input flag_n, input flag_z, input flag_c, input flag_v,
        input supported, output ready
    );
endinterface

// ===== rtl/tae_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tae_ram: generic RAM, one write port and two registered read ports
// Read data updates only when the read enable is high and holds otherwise.
// A read of the address being written returns the old contents.
// ----------------------------------------------------------------------------
module tae_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

// ===== rtl/tae_shifter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tae_shifter: barrel shifter with ARM carry rules
// LSL, LSR, ASR and ROR by an 8-bit amount; amount zero keeps the value and
// the incoming carry, amounts of the word width and above follow ARM rules.
// ----------------------------------------------------------------------------
module tae_shifter (
    input  tae_pkg::word_t       value,
    input  tae_pkg::shamt_t      amount,
    input  tae_pkg::shift_kind_t kind,
    input  logic                 carry_in,
    output tae_pkg::word_t       result,
    output logic                 carry
);
    import tae_pkg::*;

    logic [SHIFT_IDX_W-1:0] low;
    logic                   is_zero;
    logic                   is_full;
    logic                   is_over;
    logic [WORD_W:0]        lsl_w;
    logic [WORD_W:0]        lsr_w;
    logic signed [WORD_W:0] asr_w;
    logic [2*WORD_W-1:0]    ror_w;

    assign low     = amount[SHIFT_IDX_W-1:0];
    assign is_zero = (amount == '0);
    assign is_full = (amount == SHAMT_W'(WORD_W));
    assign is_over = (amount >= SHAMT_W'(WORD_W));

    // Extra bit on the shifted-out side catches the carry
    assign lsl_w = {1'b0, value} << low;
    assign lsr_w = {value, 1'b0} >> low;
    assign asr_w = $signed({value, 1'b0}) >>> low;
    assign ror_w = {value, value} >> low;

    always_comb
    begin
        result = value;
        carry  = carry_in;
        if (!is_zero)
        begin
            unique case (kind)
                SH_LSL:
                begin
                    priority if (!is_over)
                    begin
                        result = lsl_w[WORD_W-1:0];
                        carry  = lsl_w[WORD_W];
                    end
                    else if (is_full)
                    begin
                        result = '0;
                        carry  = value[0];
                    end
                    else
                    begin
                        result = '0;
                        carry  = 1'b0;
                    end
                end
                SH_LSR:
                begin
                    priority if (!is_over)
                    begin
                        result = lsr_w[WORD_W:1];
                        carry  = lsr_w[0];
                    end
                    else if (is_full)
                    begin
                        result = '0;
                        carry  = value[WORD_W-1];
                    end
                    else
                    begin
                        result = '0;
                        carry  = 1'b0;
                    end
                end
                SH_ASR:
                begin
                    if (!is_over)
                    begin
                        result = asr_w[WORD_W:1];
                        carry  = asr_w[0];
                    end
                    else
                    begin
                        result = {WORD_W{value[WORD_W-1]}};
                        carry  = value[WORD_W-1];
                    end
                end
                SH_ROR:
                begin
                    // multiples of the word width leave the value, carry is bit 31
                    result = ror_w[WORD_W-1:0];
                    carry  = ror_w[WORD_W-1];
                end
            endcase
        end
    end

endmodule

// ===== rtl/tae_alu.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tae_alu: single-pass execute logic for Thumb formats 1 to 4
// Decodes the instruction, drives one adder, the shifter and the multiplier,
// and selects the written value, destination, write flag and new flags.
// ----------------------------------------------------------------------------
module tae_alu (
    input  tae_pkg::instr_t instruction,
    input  tae_pkg::word_t  op_a,
    input  tae_pkg::word_t  op_b,
    input  tae_pkg::flags_t flags,
    output tae_pkg::exec_t  exec
);
    import tae_pkg::*;

    format_t     fmt;
    alu_op_t     alu_op;
    imm_op_t     imm_op;
    word_t       imm3;
    word_t       imm8;
    logic [IMM5_W-1:0] imm5;

    word_t       add_a;
    word_t       add_b;
    logic        add_cin;
    logic [WORD_W:0] sum;
    word_t       add_res;
    logic        add_c;
    logic        add_v;

    shift_kind_t sh_kind;
    shamt_t      sh_amount;
    word_t       sh_res;
    logic        sh_c;

    word_t       mul_res;
    word_t       value;

    assign fmt    = decode_format(instruction);
    assign alu_op = alu_op_t'(instruction[9:6]);
    assign imm_op = imm_op_t'(instruction[12:11]);
    assign imm3   = WORD_W'(instruction[8:6]);
    assign imm5   = instruction[10:6];
    assign imm8   = WORD_W'(instruction[7:0]);

    // Subtraction runs as a + ~b + carry; carry out is the ARM no-borrow
    always_comb
    begin
        add_a   = op_a;
        add_b   = op_b;
        add_cin = 1'b0;
        unique case (fmt)
            FMT_ADDSUB:
            begin
                add_b = instruction[10] ? imm3 : op_b;
                if (instruction[9])
                begin
                    add_b   = ~add_b;
                    add_cin = 1'b1;
                end
            end
            FMT_IMM:
            begin
                add_b = imm8;
                if (imm_op != IMM_ADD)
                begin
                    add_b   = ~imm8;
                    add_cin = 1'b1;
                end
            end
            FMT_ALU:
            begin
                unique case (alu_op)
                    ALU_ADC:
                    begin
                        add_cin = flags.c;
                    end
                    ALU_SBC:
                    begin
                        add_b   = ~op_b;
                        add_cin = flags.c;
                    end
                    ALU_NEG:
                    begin
                        add_a   = '0;
                        add_b   = ~op_b;
                        add_cin = 1'b1;
                    end
                    ALU_CMP:
                    begin
                        add_b   = ~op_b;
                        add_cin = 1'b1;
                    end
                    default:
                    begin
                        add_cin = 1'b0;
                    end
                endcase
            end
            default:
            begin
                add_cin = 1'b0;
            end
        endcase
    end

    assign sum     = {1'b0, add_a} + {1'b0, add_b} + {{WORD_W{1'b0}}, add_cin};
    assign add_res = sum[WORD_W-1:0];
    assign add_c   = sum[WORD_W];
    assign add_v   = (add_a[WORD_W-1] ^ add_res[WORD_W-1])
                   & (add_b[WORD_W-1] ^ add_res[WORD_W-1]);

    // Immediate LSR/ASR of zero means a full-word shift
    always_comb
    begin
        sh_kind   = SH_LSL;
        sh_amount = op_b[SHAMT_W-1:0];
        if (fmt == FMT_SHIFT)
        begin
            sh_kind = shift_kind_t'(instruction[12:11]);
            if (sh_kind != SH_LSL && imm5 == '0)
                sh_amount = SHAMT_W'(WORD_W);
            else
                sh_amount = SHAMT_W'(imm5);
        end
        else
        begin
            unique case (alu_op)
                ALU_LSR: sh_kind = SH_LSR;
                ALU_ASR: sh_kind = SH_ASR;
                ALU_ROR: sh_kind = SH_ROR;
                default: sh_kind = SH_LSL;
            endcase
        end
    end

    tae_shifter u_shifter (
        .value    (op_a),
        .amount   (sh_amount),
        .kind     (sh_kind),
        .carry_in (flags.c),
        .result   (sh_res),
        .carry    (sh_c)
    );

    assign mul_res = op_a * op_b;

    always_comb
    begin
        value          = '0;
        exec.dest      = instruction[2:0];
        exec.write     = 1'b0;
        exec.flags     = flags;
        exec.supported = 1'b1;
        unique case (fmt)
            FMT_SHIFT:
            begin
                value        = sh_res;
                exec.flags.c = sh_c;
                exec.write   = 1'b1;
            end
            FMT_ADDSUB:
            begin
                value        = add_res;
                exec.flags.c = add_c;
                exec.flags.v = add_v;
                exec.write   = 1'b1;
            end
            FMT_IMM:
            begin
                exec.dest  = instruction[10:8];
                exec.write = (imm_op != IMM_CMP);
                if (imm_op == IMM_MOV)
                begin
                    value = imm8;
                end
                else
                begin
                    value        = add_res;
                    exec.flags.c = add_c;
                    exec.flags.v = add_v;
                end
            end
            FMT_ALU:
            begin
                exec.write = 1'b1;
                unique case (alu_op)
                    ALU_AND: value = op_a & op_b;
                    ALU_EOR: value = op_a ^ op_b;
                    ALU_ORR: value = op_a | op_b;
                    ALU_BIC: value = op_a & ~op_b;
                    ALU_MVN: value = ~op_b;
                    ALU_TST:
                    begin
                        value      = op_a & op_b;
                        exec.write = 1'b0;
                    end
                    ALU_LSL, ALU_LSR, ALU_ASR, ALU_ROR:
                    begin
                        value        = sh_res;
                        exec.flags.c = sh_c;
                    end
                    ALU_ADC, ALU_SBC, ALU_NEG:
                    begin
                        value        = add_res;
                        exec.flags.c = add_c;
                        exec.flags.v = add_v;
                    end
                    ALU_CMP, ALU_CMN:
                    begin
                        value        = add_res;
                        exec.flags.c = add_c;
                        exec.flags.v = add_v;
                        exec.write   = 1'b0;
                    end
                    ALU_MUL:
                    begin
                        value        = mul_res;
                        exec.flags.c = 1'b0;
                    end
                endcase
            end
            FMT_NONE:
            begin
                exec.dest      = '0;
                exec.supported = 1'b0;
            end
        endcase
        if (exec.supported)
        begin
            exec.flags.n = value[WORD_W-1];
            exec.flags.z = (value == '0);
        end
        exec.value = value;
    end

endmodule

// ===== rtl/thumb_alu_execute_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thumb_alu_execute_core: Thumb formats 1 to 4 execute unit with R0-R7 and NZCV
// Usage:
//   issue  - sink of 16-bit instruction words (valid/ready).
//   result - source of one result word per instruction: written value,
//            destination, write flag, N/Z/C/V after the instruction and a
//            supported bit. Unsupported words change no state.
//   Result valid rises when the word moves from execute to result register.
//   Throughput is one word per cycle while the receiver does not stall: the
//   register file is read when a word is accepted and the result of the word
//   executing in that same cycle is forwarded to the word's execute stage
//   (adder, shifter or multiplier).
//   The execute stage and the result register run as a two-deep pipe; while
//   the receiver stalls the result holds, one more word waits in the execute
//   register, and ready drops once both are full.
//   Reset clears R0-R7 (through per-register valid bits, no clearing pass) and
//   the flags, and empties the pipe; a word can be accepted right after.
// ----------------------------------------------------------------------------
module thumb_alu_execute_core (
    input  logic        clk,
    input  logic        rst_n,
    tae_issue_if.sink   issue,
    tae_result_if.source result
);
    import tae_pkg::*;

    instr_t               ins_reg;
    logic                 in_valid_reg;
    logic                 hit_a_reg;
    logic                 hit_b_reg;
    logic                 live_a_reg;
    logic                 live_b_reg;
    logic [REG_COUNT-1:0] rf_valid_reg;
    flags_t               flags_reg;
    exec_t                res_reg;
    logic                 out_valid_reg;
    logic                 out_valid_next;

    logic     accept;
    logic     advance;
    logic     wr_en;
    reg_idx_t addr_a;
    reg_idx_t addr_b;
    word_t    q_a;
    word_t    q_b;
    word_t    op_a;
    word_t    op_b;
    exec_t    exec;

    assign advance     = in_valid_reg && (!out_valid_reg || result.ready);
    assign issue.ready = !in_valid_reg || advance;
    assign accept      = issue.valid && issue.ready;
    assign wr_en       = advance && exec.write;

    assign addr_a = src_a_index(issue.instruction);
    assign addr_b = src_b_index(issue.instruction);

    tae_ram #(
        .WIDTH (WORD_W),
        .DEPTH (REG_COUNT)
    ) u_regfile (
        .clk     (clk),
        .we      (wr_en),
        .waddr   (exec.dest),
        .wdata   (exec.value),
        .re      (accept),
        .raddr_a (addr_a),
        .raddr_b (addr_b),
        .rdata_a (q_a),
        .rdata_b (q_b)
    );

    // Forward the word retired in the accept cycle; never-written regs read zero
    assign op_a = hit_a_reg ? res_reg.value : (live_a_reg ? q_a : '0);
    assign op_b = hit_b_reg ? res_reg.value : (live_b_reg ? q_b : '0);

    tae_alu u_alu (
        .instruction (ins_reg),
        .op_a        (op_a),
        .op_b        (op_b),
        .flags       (flags_reg),
        .exec        (exec)
    );

    always_comb
    begin
        if (advance)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            hit_a_reg     <= 1'b0;
            hit_b_reg     <= 1'b0;
            live_a_reg    <= 1'b0;
            live_b_reg    <= 1'b0;
            rf_valid_reg  <= '0;
            flags_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                in_valid_reg <= 1'b1;
                hit_a_reg    <= wr_en && (exec.dest == addr_a);
                hit_b_reg    <= wr_en && (exec.dest == addr_b);
                live_a_reg   <= rf_valid_reg[addr_a];
                live_b_reg   <= rf_valid_reg[addr_b];
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (wr_en)
            begin
                rf_valid_reg[exec.dest] <= 1'b1;
            end
            if (advance)
            begin
                flags_reg <= exec.flags;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ins_reg <= issue.instruction;
        end
        if (advance)
        begin
            res_reg <= exec;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.result_value = res_reg.value;
    assign result.dest_index   = res_reg.dest;
    assign result.reg_written  = res_reg.write;
    assign result.flag_n       = res_reg.flags.n;
    assign result.flag_z       = res_reg.flags.z;
    assign result.flag_c       = res_reg.flags.c;
    assign result.flag_v       = res_reg.flags.v;
    assign result.supported    = res_reg.supported;

    // The last result shown always carries the architectural flags
    a_flags_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> res_reg.flags == flags_reg)
        else $error("result flags differ from flag register");

    // A forwarded operand must come from the held result that wrote that register
    a_fwd_source: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && hit_a_reg |-> res_reg.write && res_reg.dest == src_a_index(ins_reg))
        else $error("forwarded operand without matching write");

    // A register write marks the entry live from then on
    a_write_live: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> rf_valid_reg[$past(exec.dest)])
        else $error("written register not marked valid");

    // Unsupported words never touch the register file
    a_no_write_unsupported: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !exec.supported |-> !exec.write && exec.flags == flags_reg)
        else $error("unsupported word changes state");

    // Issue stalls only when both pipe stages are full and the receiver is stalled
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !issue.ready |-> in_valid_reg && out_valid_reg && !result.ready)
        else $error("issue stalled without back pressure");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the Thumb ALU execute core
// Drives Thumb instruction words into the issue channel and checks every
// result word against an in-bench model of R0-R7 and NZCV. A directed opening
// covers immediate extremes, the shift-by-zero rules, register shift amounts
// and every ALU opcode, then random words run through four idle/stall phases.
// ----------------------------------------------------------------------------
module tb_top;
    import tae_pkg::*;

    localparam int   CLK_PERIOD       = 10;
    localparam int   WORDS_PER_PHASE  = 400;
    localparam int   DRAIN_CYCLES     = 10;
    localparam int   CYCLE_LIMIT      = 200000;
    localparam int   REPORT_MAX       = 10;
    localparam instr_t BX_R0_WORD     = 16'h4700;
    localparam instr_t SWI_WORD       = 16'hDF00;

    logic clk;
    logic rst_n;

    tae_issue_if  issue_ch ();
    tae_result_if result_ch ();

    thumb_alu_execute_core uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .issue  (issue_ch),
        .result (result_ch)
    );

    // model state
    word_t  model_regs [REG_COUNT];
    flags_t model_flags;

    instr_t instr_queue [$];
    exec_t  expected_results [$];

    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    logic        issue_taken;
    int unsigned cycle_count;
    int unsigned mismatch_count;
    int unsigned words_accepted;
    int unsigned results_checked;
    int unsigned unsupported_seen;
    exec_t       observed;
    exec_t       predicted;

    // ------------------------------------------------------------------------
    // Instruction encoders
    // ------------------------------------------------------------------------
    function automatic instr_t enc_shift(shift_kind_t kind, logic [4:0] amt,
                                         reg_idx_t rs, reg_idx_t rd);
        return {FMT_SHIFT_CODE, kind, amt, rs, rd};
    endfunction

    function automatic instr_t enc_addsub(logic imm, logic sub, logic [2:0] rn,
                                          reg_idx_t rs, reg_idx_t rd);
        return {FMT_ADDSUB_CODE, imm, sub, rn, rs, rd};
    endfunction

    function automatic instr_t enc_imm(imm_op_t op, reg_idx_t rd, logic [7:0] imm);
        return {FMT_IMM_CODE, op, rd, imm};
    endfunction

    function automatic instr_t enc_alu(alu_op_t op, reg_idx_t rs, reg_idx_t rd);
        return {FMT_ALU_CODE, op, rs, rd};
    endfunction

    function automatic format_t classify_word(instr_t ins);
        if (ins[15:11] == FMT_ADDSUB_CODE)
            return FMT_ADDSUB;
        if (ins[15:13] == FMT_SHIFT_CODE)
            return FMT_SHIFT;
        if (ins[15:13] == FMT_IMM_CODE)
            return FMT_IMM;
        if (ins[15:10] == FMT_ALU_CODE)
            return FMT_ALU;
        return FMT_NONE;
    endfunction

    // ------------------------------------------------------------------------
    // Barrel shifter and adder, each returning {carry, value} or {v, c, value}
    // ------------------------------------------------------------------------
    function automatic logic [32:0] shift_left(word_t v, int unsigned n, logic cin);
        if (n == 0)
            return {cin, v};
        if (n < 32)
            return {v[32-n], v << n};
        if (n == 32)
            return {v[0], 32'h0};
        return 33'h0;
    endfunction

    function automatic logic [32:0] shift_right(word_t v, int unsigned n, logic cin);
        if (n == 0)
            return {cin, v};
        if (n < 32)
            return {v[n-1], v >> n};
        if (n == 32)
            return {v[31], 32'h0};
        return 33'h0;
    endfunction

    function automatic logic [32:0] shift_arith(word_t v, int unsigned n, logic cin);
        if (n == 0)
            return {cin, v};
        if (n < 32)
            return {v[n-1], word_t'($signed(v) >>> n)};
        return {v[31], {WORD_W{v[31]}}};
    endfunction

    function automatic logic [32:0] rotate_right(word_t v, int unsigned n, logic cin);
        word_t       rot;
        int unsigned k;
        if (n == 0)
            return {cin, v};
        k = n % 32;
        if (k == 0)
            return {v[31], v};
        rot = (v >> k) | (v << (32 - k));
        return {rot[31], rot};
    endfunction

    // subtraction is a + ~b + carry-in; carry out is the ARM not-borrow
    function automatic logic [33:0] add_carry(word_t a, word_t b, logic cin);
        logic [32:0] sum;
        word_t       r;
        sum = {1'b0, a} + {1'b0, b} + {32'h0, cin};
        r   = sum[31:0];
        return {((a[31] ^ r[31]) & (b[31] ^ r[31])), sum[32], r};
    endfunction

    // ------------------------------------------------------------------------
    // Execute one word against the model registers and flags
    // ------------------------------------------------------------------------
    function automatic exec_t execute_word(instr_t ins);
        exec_t       r;
        word_t       a;
        word_t       b;
        reg_idx_t    rd;
        reg_idx_t    rs;
        int unsigned amt;
        logic        cin;
        r           = '0;
        r.flags     = model_flags;
        r.supported = 1'b1;
        cin         = model_flags.c;
        rd          = ins[2:0];
        rs          = ins[5:3];
        case (classify_word(ins))
            FMT_ADDSUB:
            begin
                a = model_regs[rs];
                b = ins[10] ? {29'h0, ins[8:6]} : model_regs[ins[8:6]];
                if (ins[9])
                    {r.flags.v, r.flags.c, r.value} = add_carry(a, ~b, 1'b1);
                else
                    {r.flags.v, r.flags.c, r.value} = add_carry(a, b, 1'b0);
                r.dest  = rd;
                r.write = 1'b1;
            end
            FMT_SHIFT:
            begin
                a   = model_regs[rs];
                amt = ins[10:6];
                case (shift_kind_t'(ins[12:11]))
                    SH_LSL:  {r.flags.c, r.value} = shift_left(a, amt, cin);
                    SH_LSR:  {r.flags.c, r.value} = shift_right(a, amt == 0 ? 32 : amt, cin);
                    default: {r.flags.c, r.value} = shift_arith(a, amt == 0 ? 32 : amt, cin);
                endcase
                r.dest  = rd;
                r.write = 1'b1;
            end
            FMT_IMM:
            begin
                r.dest = ins[10:8];
                a      = model_regs[ins[10:8]];
                b      = {24'h0, ins[7:0]};
                r.write = 1'b1;
                case (imm_op_t'(ins[12:11]))
                    IMM_MOV: r.value = b;
                    IMM_CMP:
                    begin
                        {r.flags.v, r.flags.c, r.value} = add_carry(a, ~b, 1'b1);
                        r.write = 1'b0;
                    end
                    IMM_ADD: {r.flags.v, r.flags.c, r.value} = add_carry(a, b, 1'b0);
                    default: {r.flags.v, r.flags.c, r.value} = add_carry(a, ~b, 1'b1);
                endcase
            end
            FMT_ALU:
            begin
                a       = model_regs[rd];
                b       = model_regs[rs];
                amt     = b[7:0];
                r.dest  = rd;
                r.write = 1'b1;
                case (alu_op_t'(ins[9:6]))
                    ALU_AND: r.value = a & b;
                    ALU_EOR: r.value = a ^ b;
                    ALU_LSL: {r.flags.c, r.value} = shift_left(a, amt, cin);
                    ALU_LSR: {r.flags.c, r.value} = shift_right(a, amt, cin);
                    ALU_ASR: {r.flags.c, r.value} = shift_arith(a, amt, cin);
                    ALU_ADC: {r.flags.v, r.flags.c, r.value} = add_carry(a, b, cin);
                    ALU_SBC: {r.flags.v, r.flags.c, r.value} = add_carry(a, ~b, cin);
                    ALU_ROR: {r.flags.c, r.value} = rotate_right(a, amt, cin);
                    ALU_TST:
                    begin
                        r.value = a & b;
                        r.write = 1'b0;
                    end
                    ALU_NEG: {r.flags.v, r.flags.c, r.value} = add_carry('0, ~b, 1'b1);
                    ALU_CMP:
                    begin
                        {r.flags.v, r.flags.c, r.value} = add_carry(a, ~b, 1'b1);
                        r.write = 1'b0;
                    end
                    ALU_CMN:
                    begin
                        {r.flags.v, r.flags.c, r.value} = add_carry(a, b, 1'b0);
                        r.write = 1'b0;
                    end
                    ALU_ORR: r.value = a | b;
                    ALU_MUL:
                    begin
                        r.value   = a * b;
                        r.flags.c = 1'b0;
                    end
                    ALU_BIC: r.value = a & ~b;
                    default: r.value = ~b;
                endcase
            end
            default: r.supported = 1'b0;
        endcase
        if (r.supported)
        begin
            r.flags.n = r.value[31];
            r.flags.z = (r.value == '0);
        end
        if (r.write)
            model_regs[r.dest] = r.value;
        model_flags = r.flags;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Random words: mostly executed formats, with immediates that often land
    // on shift-amount boundaries so register shifts hit the edge rules
    // ------------------------------------------------------------------------
    function automatic logic [7:0] pick_imm8();
        case ($urandom_range(11))
            0:       return 8'd0;
            1:       return 8'd1;
            2:       return 8'd31;
            3:       return 8'd32;
            4:       return 8'd33;
            5:       return 8'd64;
            6:       return 8'd255;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic instr_t random_word();
        int unsigned sel;
        instr_t      ins;
        sel = $urandom_range(99);
        if (sel < 40)
            ins = enc_alu(alu_op_t'($urandom_range(15)), 3'($urandom), 3'($urandom));
        else if (sel < 60)
            ins = enc_imm(IMM_MOV, 3'($urandom), pick_imm8());
        else if (sel < 70)
            ins = enc_imm(imm_op_t'($urandom_range(3, 1)), 3'($urandom), 8'($urandom));
        else if (sel < 80)
            ins = enc_shift(shift_kind_t'($urandom_range(2)), 5'($urandom),
                            3'($urandom), 3'($urandom));
        else if (sel < 90)
            ins = enc_addsub(1'($urandom), 1'($urandom), 3'($urandom),
                             3'($urandom), 3'($urandom));
        else if (sel < 95)
        begin
            ins = instr_t'($urandom);
            while (classify_word(ins) != FMT_NONE)
                ins = instr_t'($urandom);
        end
        else
            ins = instr_t'($urandom);
        return ins;
    endfunction

    // ------------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Driver: issue words and toggle result ready on the falling edge
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
            issue_ch.valid <= 1'b0;
        else if (!issue_ch.valid || issue_taken)
        begin
            if (instr_queue.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                issue_ch.valid       <= 1'b1;
                issue_ch.instruction <= instr_queue.pop_front();
            end
            else
            begin
                issue_ch.valid       <= 1'b0;
                issue_ch.instruction <= instr_t'($urandom);
            end
        end
        result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // ------------------------------------------------------------------------
    // Monitor: predict on issue accept, check on result accept
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        issue_taken <= rst_n && issue_ch.valid && issue_ch.ready;
        if (rst_n && issue_ch.valid && issue_ch.ready)
        begin
            expected_results.push_back(execute_word(issue_ch.instruction));
            words_accepted++;
        end
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            observed.value     = result_ch.result_value;
            observed.dest      = result_ch.dest_index;
            observed.write     = result_ch.reg_written;
            observed.flags     = {result_ch.flag_n, result_ch.flag_z,
                                  result_ch.flag_c, result_ch.flag_v};
            observed.supported = result_ch.supported;
            if (expected_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX)
                    $display("%0t: result word with nothing outstanding: value %h rd %0d",
                             $realtime, observed.value, observed.dest);
            end
            else
            begin
                predicted = expected_results.pop_front();
                results_checked++;
                if (!predicted.supported)
                    unsupported_seen++;
                if (observed !== predicted)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                    begin
                        $display("%0t: result %0d expected value %h rd %0d wr %b nzcv %b sup %b",
                                 $realtime, results_checked,
                                 predicted.value, predicted.dest, predicted.write,
                                 predicted.flags, predicted.supported);
                        $display("    got value %h rd %0d wr %b nzcv %b sup %b",
                                 observed.value, observed.dest, observed.write,
                                 observed.flags, observed.supported);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[thumb_alu_execute_core] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        int      phase;
        int      op;
        alu_op_t cur_op;
        issue_ch.valid       = 1'b0;
        issue_ch.instruction = '0;
        result_ch.ready      = 1'b0;
        issue_taken          = 1'b0;
        cycle_count          = 0;
        mismatch_count       = 0;
        words_accepted       = 0;
        results_checked      = 0;
        unsupported_seen     = 0;
        send_idle_pct        = 0;
        recv_stall_pct       = 0;
        model_flags          = '0;
        for (int i = 0; i < REG_COUNT; i++)
            model_regs[i] = '0;

        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // immediate extremes and the shift-by-zero rules
        instr_queue.push_back(enc_imm(IMM_MOV, 3'd0, 8'hFF));
        instr_queue.push_back(enc_imm(IMM_MOV, 3'd1, 8'h00));
        instr_queue.push_back(enc_alu(ALU_MVN, 3'd1, 3'd2));
        instr_queue.push_back(enc_shift(SH_LSL, 5'd24, 3'd0, 3'd3));
        instr_queue.push_back(enc_shift(SH_LSL, 5'd0, 3'd2, 3'd4));
        instr_queue.push_back(enc_shift(SH_LSR, 5'd0, 3'd3, 3'd5));
        instr_queue.push_back(enc_shift(SH_ASR, 5'd0, 3'd3, 3'd6));
        instr_queue.push_back(enc_imm(IMM_MOV, 3'd7, 8'd32));
        instr_queue.push_back(enc_addsub(1'b0, 1'b0, 3'd0, 3'd2, 3'd5));
        instr_queue.push_back(enc_addsub(1'b1, 1'b1, 3'd7, 3'd1, 3'd6));
        instr_queue.push_back(enc_imm(IMM_CMP, 3'd1, 8'h00));
        instr_queue.push_back(enc_imm(IMM_ADD, 3'd2, 8'hFF));
        instr_queue.push_back(enc_imm(IMM_SUB, 3'd1, 8'hFF));
        // every ALU opcode; shifts take R7 (32), so ROR hits the multiple-of-32 case
        for (op = 0; op < 16; op++)
        begin
            cur_op = alu_op_t'(op[3:0]);
            if (cur_op == ALU_LSL || cur_op == ALU_LSR || cur_op == ALU_ASR ||
                cur_op == ALU_ROR)
                instr_queue.push_back(enc_alu(cur_op, 3'd7, 3'((op + 3) % 7)));
            else
                instr_queue.push_back(enc_alu(cur_op, 3'(op % 7), 3'((op + 3) % 7)));
        end
        // words outside the executed formats
        instr_queue.push_back(BX_R0_WORD);
        instr_queue.push_back(SWI_WORD);

        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 46;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 46;
                end
                default:
                begin
                    send_idle_pct  = 25;
                    recv_stall_pct = 25;
                end
            endcase
            repeat (WORDS_PER_PHASE) instr_queue.push_back(random_word());
            // hold until the phase has fully drained
            while (instr_queue.size() != 0 || issue_ch.valid || expected_results.size() != 0)
                @(posedge clk);
        end

        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Executed %0d words through four idle/stall phases; %0d results checked,",
                 words_accepted, results_checked);
        $display("%0d of them unsupported words, %0d mismatches.",
                 unsupported_seen, mismatch_count);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("[thumb_alu_execute_core] OK");
        else
            $display("[thumb_alu_execute_core] ERROR");
        $finish;
    end

endmodule
